[hw/rtl/i2s_tmt_pkg.sv]
// ----------------------------------------------------------------------------
// I2S tone transmitter package
// Shared types, register indexes, defaults and sine polynomial coefficients.
// ----------------------------------------------------------------------------
package i2s_tmt_pkg;

  localparam int WORD_BITS_DEFAULT        = 16;
  localparam int SINE_TABLE_DEPTH_DEFAULT = 1024;

  localparam int SAMPLE_BITS = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int POLY_W      = 17;
  localparam int PROD_W      = 2 * POLY_W;
  localparam int MAG_W       = 15;

  localparam logic [7:0]  GAIN_RESET       = 8'd100;
  localparam logic [31:0] PHASE_STEP_RESET = 32'd118111601;
  localparam logic [4:0]  BIT_COUNT_MAX    = 5'd31;
  localparam logic [POLY_W-1:0] POLY_SEED  = 17'd11;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GAIN       = 1'b0,
    REG_PHASE_STEP = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_WORD_SELECT = 1'b0,
    OP_BIT_CLOCK   = 1'b1
  } pin_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_SQR,
    ST_POLY,
    ST_SINE,
    ST_SCALE
  } seq_state_t;

  // Horner coefficients, Q16, applied after the seed value
  function automatic logic [POLY_W-1:0] poly_coef(input logic [1:0] idx);
    logic [POLY_W-1:0] c;
    case (idx)
      2'd0:    c = 17'd307;
      2'd1:    c = 17'd5223;
      2'd2:    c = 17'd42334;
      2'd3:    c = 17'd102944;
      default: c = 17'd0;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/i2s_tone_microphone_transmitter.sv]
// ----------------------------------------------------------------------------
// I2S tone microphone transmitter
// Left-channel I2S data source that sends a scaled sine test tone.
// ----------------------------------------------------------------------------
// Each input transaction reports one pin edge. A rising bit clock edge
// yields one data bit on the master side; a rising word select or falling
// bit clock edge yields nothing. A falling word select edge starts a left
// frame and keeps the block busy for one phase add, one squaring, four
// polynomial steps, one sine product and one gain product; all but the
// phase add go through a single shared 17x17 multiplier.
// Reset runs the same sequence to form the first tone sample.
// SINE_TABLE_DEPTH must be a power of two. Register writes must be made so
// they apply at the next frame start; the block itself does not enforce this.
module i2s_tone_microphone_transmitter #(
  parameter int WORD_BITS        = i2s_tmt_pkg::WORD_BITS_DEFAULT,
  parameter int SINE_TABLE_DEPTH = i2s_tmt_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // level, ws_level
  input  logic                                s_tuser,   // op
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,   // data_bit
  input  logic                                cfg_we,
  input  logic [i2s_tmt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [i2s_tmt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(SINE_TABLE_DEPTH);
  localparam int SH = 18 - AW;
  localparam int PW = i2s_tmt_pkg::POLY_W;
  localparam int MW = i2s_tmt_pkg::MAG_W;
  localparam logic [5:0] WORD_LEN = 6'(WORD_BITS);
  localparam logic [5:0] SAMPLE_LEN = 6'(i2s_tmt_pkg::SAMPLE_BITS);

  i2s_tmt_pkg::seq_state_t state, state_next;

  logic [7:0]              gain;
  logic [31:0]             phase_step;
  logic [31:0]             phase_acc;
  logic [15:0]             tone_sample;
  logic [4:0]              bit_count;
  logic                    delay_done;
  logic [PW-1:0]           t2;
  logic [PW-1:0]           poly;
  logic [1:0]              coef_idx;
  logic [MW-1:0]           mag;

  logic [17:0]             u;
  logic [PW-1:0]           t_cur;
  logic [14:0]             gain_k;
  logic [PW-1:0]           mul_a;
  logic [PW-1:0]           mul_b;
  logic [i2s_tmt_pkg::PROD_W-1:0] prod;
  logic [PW-1:0]           sine_s;
  logic [18:0]             scaled;
  logic [15:0]             scaled_mag;
  logic                    take;
  logic                    frame_start;
  logic                    bit_edge;
  logic                    word_bit;
  logic                    data_bit;

  assign take        = s_tvalid && s_tready;
  assign frame_start = take && (s_tuser == i2s_tmt_pkg::OP_WORD_SELECT) && !s_tdata[0];
  assign bit_edge    = take && (s_tuser == i2s_tmt_pkg::OP_BIT_CLOCK) && s_tdata[0];

  // quarter-wave argument from the table index
  assign u      = 18'(phase_acc[31 -: AW]) << SH;
  assign t_cur  = u[16] ? (17'h10000 - {1'b0, u[15:0]}) : {1'b0, u[15:0]};
  assign gain_k = (15'(gain) << 7) - (15'(gain) << 3);

  assign prod   = mul_a * mul_b;
  assign sine_s = PW'(prod >> 17);
  assign scaled = 19'(prod >> 15);
  assign scaled_mag = (scaled > 19'd32767) ? 16'd32767 : scaled[15:0];

  always_comb begin
    word_bit = 1'b0;
    if ((6'(bit_count) < WORD_LEN) && (6'(bit_count) < SAMPLE_LEN)) begin
      word_bit = tone_sample[4'(i2s_tmt_pkg::SAMPLE_BITS - 1) - bit_count[3:0]];
    end
  end

  assign data_bit = (s_tdata[1] || !delay_done) ? 1'b0 : word_bit;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      i2s_tmt_pkg::ST_IDLE:  if (frame_start) state_next = i2s_tmt_pkg::ST_ACC;
      i2s_tmt_pkg::ST_ACC:   state_next = i2s_tmt_pkg::ST_SQR;
      i2s_tmt_pkg::ST_SQR:   state_next = i2s_tmt_pkg::ST_POLY;
      i2s_tmt_pkg::ST_POLY:  if (coef_idx == 2'd3) state_next = i2s_tmt_pkg::ST_SINE;
      i2s_tmt_pkg::ST_SINE:  state_next = i2s_tmt_pkg::ST_SCALE;
      i2s_tmt_pkg::ST_SCALE: state_next = i2s_tmt_pkg::ST_IDLE;
      default:               state_next = i2s_tmt_pkg::ST_IDLE;
    endcase
  end

  // outputs and multiplier operand select
  always_comb begin
    s_tready = 1'b0;
    mul_a    = t_cur;
    mul_b    = t_cur;
    case (state)
      i2s_tmt_pkg::ST_IDLE:  s_tready = !m_tvalid || m_tready;
      i2s_tmt_pkg::ST_POLY: begin
        mul_a = t2;
        mul_b = poly;
      end
      i2s_tmt_pkg::ST_SINE:  mul_b = poly;
      i2s_tmt_pkg::ST_SCALE: begin
        mul_a = PW'(mag);
        mul_b = PW'(gain_k);
      end
      default: begin
        mul_a = t_cur;
        mul_b = t_cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= i2s_tmt_pkg::ST_ACC;
      gain       <= i2s_tmt_pkg::GAIN_RESET;
      phase_step <= i2s_tmt_pkg::PHASE_STEP_RESET;
      phase_acc  <= '0;
      bit_count  <= '0;
      delay_done <= 1'b0;
      coef_idx   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          i2s_tmt_pkg::REG_GAIN:       gain <= cfg_wdata[7:0];
          i2s_tmt_pkg::REG_PHASE_STEP: phase_step <= cfg_wdata;
          default: ;
        endcase
      end
      if (bit_edge) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (frame_start) begin
        bit_count  <= '0;
        delay_done <= 1'b0;
      end
      if (bit_edge) begin
        if (!s_tdata[1]) begin
          if (!delay_done) begin
            delay_done <= 1'b1;
          end else if (bit_count != i2s_tmt_pkg::BIT_COUNT_MAX) begin
            bit_count <= bit_count + 5'd1;
          end
        end
      end
      case (state)
        i2s_tmt_pkg::ST_ACC:  phase_acc <= phase_acc + phase_step;
        i2s_tmt_pkg::ST_SQR:  coef_idx <= '0;
        i2s_tmt_pkg::ST_POLY: coef_idx <= coef_idx + 2'd1;
        default: ;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (bit_edge) m_tdata <= {7'd0, data_bit};
    case (state)
      i2s_tmt_pkg::ST_SQR: begin
        t2   <= PW'(prod >> 16);
        poly <= i2s_tmt_pkg::POLY_SEED;
      end
      i2s_tmt_pkg::ST_POLY:
        poly <= i2s_tmt_pkg::poly_coef(coef_idx) - PW'(prod >> 16);
      i2s_tmt_pkg::ST_SINE:
        mag <= (sine_s > 17'd32767) ? 15'h7FFF : sine_s[MW-1:0];
      i2s_tmt_pkg::ST_SCALE:
        tone_sample <= u[17] ? (16'd0 - scaled_mag) : scaled_mag;
      default: ;
    endcase
  end

endmodule

[hw/rtl/i2s_tmt_checker.sv]
// ----------------------------------------------------------------------------
// I2S tone transmitter checker
// Port-level assertions on handshake and sequencing behavior.
// ----------------------------------------------------------------------------
module i2s_tmt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [7:0]                          s_tdata,
  input logic                                s_tuser,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [7:0]                          m_tdata
);

  logic s_xfer;
  assign s_xfer = s_tvalid && s_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_frame_busy: assert property (@(posedge clk) disable iff (rst)
    s_xfer && (s_tuser == i2s_tmt_pkg::OP_WORD_SELECT) && !s_tdata[0] |=> !s_tready)
    else $error("frame start did not hold off input");

  a_bit_result: assert property (@(posedge clk) disable iff (rst)
    s_xfer && (s_tuser == i2s_tmt_pkg::OP_BIT_CLOCK) && s_tdata[0] |=> m_tvalid)
    else $error("rising bit clock gave no result");

  a_ws_silent: assert property (@(posedge clk) disable iff (rst)
    s_xfer && (s_tuser == i2s_tmt_pkg::OP_WORD_SELECT) && !m_tvalid |=> !m_tvalid)
    else $error("word select transaction gave a result");

endmodule

bind i2s_tone_microphone_transmitter i2s_tmt_checker u_i2s_tmt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2S tone transmitter testbench
// Drives pin edge transactions and checks each serial data bit against a
// behavioral tone predictor, over several gain and phase step settings.
// ----------------------------------------------------------------------------
import i2s_tmt_pkg::*;

class tone_scoreboard;
  int word_bits;
  int table_depth;
  bit [7:0]         gain_reg;
  bit [31:0]        step_reg;
  bit [31:0]        phase_acc;
  logic signed [15:0] tone_sample;
  int unsigned      bit_count;
  bit               delay_done;
  bit               expected_bits[$];
  int               mismatches;

  function new(int wbits, int depth);
    word_bits   = wbits;
    table_depth = depth;
    mismatches  = 0;
    gain_reg    = GAIN_RESET;
    step_reg    = PHASE_STEP_RESET;
    phase_acc   = '0;
    start_frame();
  endfunction

  function automatic int sine_of_phase(bit [31:0] phase);
    bit [63:0] idx, u, r, t, t2, p, mag;
    bit [1:0]  quad;
    idx  = ({32'd0, phase} * 64'(table_depth)) >> 32;
    u    = (idx << 18) / 64'(table_depth);
    quad = u[17:16];
    r    = u & 64'hFFFF;
    t    = quad[0] ? (64'd65536 - r) : r;
    t2   = (t * t) >> 16;
    p    = 64'd11;
    p    = 64'd307 - ((t2 * p) >> 16);
    p    = 64'd5223 - ((t2 * p) >> 16);
    p    = 64'd42334 - ((t2 * p) >> 16);
    p    = 64'd102944 - ((t2 * p) >> 16);
    mag  = ((t * p) >> 16) >> 1;
    if (mag > 64'd32767) mag = 64'd32767;
    return quad[1] ? -int'(mag) : int'(mag);
  endfunction

  function automatic logic signed [15:0] tone_for_phase(bit [31:0] phase);
    int        s;
    bit [63:0] mag;
    s   = sine_of_phase(phase);
    mag = 64'(s < 0 ? -s : s);
    mag = (mag * 64'(gain_reg) * 64'd120) >> 15;
    if (s < 0) begin
      if (mag > 64'd32768) mag = 64'd32768;
      return 16'(-int'(mag));
    end
    if (mag > 64'd32767) mag = 64'd32767;
    return 16'(mag);
  endfunction

  function void start_frame();
    bit_count   = 0;
    delay_done  = 1'b0;
    phase_acc   = phase_acc + step_reg;
    tone_sample = tone_for_phase(phase_acc);
  endfunction

  function void set_config(bit [7:0] g, bit [31:0] step);
    gain_reg = g;
    step_reg = step;
  endfunction

  function bit slot_bit(int unsigned k);
    if (k >= word_bits || k >= SAMPLE_BITS) return 1'b0;
    return tone_sample[SAMPLE_BITS - 1 - k];
  endfunction

  function void note_edge(pin_op_t op, bit level, bit ws);
    bit data_bit;
    if (op == OP_WORD_SELECT) begin
      if (!level) start_frame();
      return;
    end
    if (!level) return;
    if (ws) begin
      data_bit = 1'b0;
    end else if (!delay_done) begin
      delay_done = 1'b1;
      data_bit   = 1'b0;
    end else begin
      data_bit = slot_bit(bit_count);
      if (bit_count < BIT_COUNT_MAX) bit_count++;
    end
    expected_bits.push_back(data_bit);
  endfunction

  task report(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_data_bit(bit data_bit);
    bit want;
    if (expected_bits.size() == 0) begin
      report($sformatf("data_bit %0b with nothing expected", data_bit));
      return;
    end
    want = expected_bits.pop_front();
    if (data_bit !== want)
      report($sformatf("data_bit got %0b want %0b", data_bit, want));
  endtask

  function int pending();
    return expected_bits.size();
  endfunction
endclass

module tb;
  localparam int WORD_BITS        = WORD_BITS_DEFAULT;
  localparam int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEFAULT;
  localparam int QUIET_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 12;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = '0;   // level, ws_level
  logic                   s_tuser = OP_WORD_SELECT;   // op
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [7:0]             m_tdata;        // data_bit
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_GAIN;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  tone_scoreboard sb;
  int s_idle_pct;
  int r_idle_pct;
  int items_sent;
  int quiet_cycles;

  i2s_tone_microphone_transmitter #(
    .WORD_BITS(WORD_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= r_idle_pct);
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_edge(pin_op_t'(s_tuser), s_tdata[0], s_tdata[1]);
    if (!rst && m_tvalid && m_tready)
      sb.check_data_bit(m_tdata[0]);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_edge(pin_op_t op, bit level, bit ws);
    while ($urandom_range(0, 99) < s_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, ws, level};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(bit [7:0] g, bit [31:0] step);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GAIN;
    cfg_wdata <= {24'd0, g};
    @(posedge clk);
    cfg_index <= REG_PHASE_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(g, step);
    @(posedge clk);
  endtask

  // one left frame: falling ws, delay clock, word bits, then right half
  task automatic run_frame();
    int n_bits;
    int i;
    n_bits = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 20);
    send_edge(OP_WORD_SELECT, 1'b0, 1'($urandom_range(0, 1)));
    for (i = 0; i <= n_bits; i++) begin
      send_edge(OP_BIT_CLOCK, 1'b0, 1'b0);
      send_edge(OP_BIT_CLOCK, 1'b1, 1'b0);
    end
    send_edge(OP_WORD_SELECT, 1'b1, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 3)) send_edge(OP_BIT_CLOCK, 1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic run_directed();
    int i;
    send_edge(OP_BIT_CLOCK, 1'b1, 1'b1);
    send_edge(OP_BIT_CLOCK, 1'b0, 1'b1);
    send_edge(OP_WORD_SELECT, 1'b1, 1'b0);
    send_edge(OP_WORD_SELECT, 1'b0, 1'b1);
    send_edge(OP_BIT_CLOCK, 1'b0, 1'b0);
    send_edge(OP_BIT_CLOCK, 1'b1, 1'b0);
    for (i = 0; i < 18; i++) send_edge(OP_BIT_CLOCK, 1'b1, 1'b0);
    send_edge(OP_BIT_CLOCK, 1'b1, 1'b1);
  endtask

  initial begin
    int phase;
    int target;
    sb = new(WORD_BITS, SINE_TABLE_DEPTH);
    s_idle_pct   = 14;
    r_idle_pct   = 58;
    items_sent   = 0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (20) @(posedge clk);

    run_directed();

    for (phase = 1; phase <= 5; phase++) begin
      drain_and_settle();
      case (phase / 2)
        0: begin
          s_idle_pct = 14;
          r_idle_pct = 58;
        end
        1: begin
          s_idle_pct = 58;
          r_idle_pct = 14;
        end
        default: begin
          s_idle_pct = 0;
          r_idle_pct = 0;
        end
      endcase
      case (phase)
        1: write_config(8'd0, 32'd0);
        2: write_config(8'd255, 32'hFFFF_FFFF);
        3: write_config(8'($urandom_range(1, 254)), $urandom);
        4: write_config(GAIN_RESET, 32'h4000_0000);
        default: write_config(8'($urandom_range(0, 255)), 32'($urandom_range(1, 32'h00FF_FFFF)));
      endcase
      target = items_sent + 205;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 20)
          send_edge(pin_op_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        else
          run_frame();
      end
    end

    drain_and_settle();
    if (sb.pending() > 0)
      sb.report($sformatf("%0d data bits never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
